// ===== hdl/utx_pkg.sv =====
`timescale 1ns / 1ps

package utx_pkg;

   localparam int FIFO_DEPTH    = 16;
   localparam int PREAMBLE_BITS = 3;
   localparam int STOP_BITS     = 2;

   localparam int PTR_W    = $clog2(FIFO_DEPTH);
   // count never exceeds FIFO_DEPTH - 1, so pointer width is enough
   localparam int CNT_W    = PTR_W;
   localparam int LEN_W    = 4;
   localparam int CMP_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int FIFO_CAP = FIFO_DEPTH - 1;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_PRE   = 5'b00010,
      PH_START = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_STOP  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] wr_data;
   } fifo_ctl_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [7:0]       rd_data;
   } fifo_sts_type;

endpackage

// ===== hdl/utx_fifo.sv =====
`timescale 1ns / 1ps

module utx_fifo
   import utx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  fifo_ctl_type ctl,
   output fifo_sts_type sts
);

   logic [7:0]       store_ff [FIFO_DEPTH];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(FIFO_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      rd_ptr_in = ctl.pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = ctl.push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      count_in  = count_ff + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         store_ff[wr_ptr_ff] <= ctl.wr_data;
      end
      // head byte kept registered; a byte written into the head slot bypasses the store
      if (ctl.push && (wr_ptr_ff == rd_ptr_in)) begin
         rd_data_ff <= ctl.wr_data;
      end else begin
         rd_data_ff <= store_ff[rd_ptr_in];
      end
   end

   assign sts.count   = count_ff;
   assign sts.rd_data = rd_data_ff;

endmodule

// ===== hdl/uart_tx_fifo_serializer_core.sv =====
`timescale 1ns / 1ps

// UART 8N2 transmitter with a byte FIFO, driven one item per baud tick or write.
// Input channel req_*: tuser[0] selects the item kind (0 = baud tick, 1 = write
// a message byte). A first byte carries the message length; a message that does
// not fit in the free FIFO space is refused whole. The FIFO holds at most
// FIFO_DEPTH - 1 bytes.
// Result channel rsp_*: one item per input item, with the line level after that
// item, the accept flag of a write, busy and the FIFO fill level.
// An item's result is registered at the edge that accepts it and shown on
// rsp_tvalid from then on. An item is taken every
// cycle as long as the result register is empty or being drained, so the
// sustained rate is one item per clock; the only limit is the single result
// register, and req_tready drops only while a result waits and rsp_tready is
// low. All work for an item is one FIFO access plus the bit sequencer step.
// Reset (synchronous, active high) empties the FIFO, sets the line idle high
// and clears the result valid flag; no clearing pass is needed.
module uart_tx_fifo_serializer_core
   import utx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // data_byte[7:0], msg_first[8], msg_len[12:9], zero[15:13]
   input  logic [0:0]  req_tuser,  // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // tx_line[0], accepted[1], busy_res[2], fifo_level[6:3], zero[7]
);

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic       reject_ff, reject_in;
   logic       line_ff, line_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   fifo_ctl_type fifo_ctl;
   fifo_sts_type fifo_sts;

   logic             req_fire;
   logic             is_write;
   logic [7:0]       wr_byte;
   logic             wr_first;
   logic [LEN_W-1:0] wr_len;
   logic [CNT_W-1:0] room;
   logic [CNT_W-1:0] count_next;
   logic             acc;
   logic             frame_done;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_write   = req_tuser[0];
   assign wr_byte    = req_tdata[7:0];
   assign wr_first   = req_tdata[8];
   assign wr_len     = req_tdata[12:9];
   assign room       = CNT_W'(FIFO_CAP) - fifo_sts.count;

   utx_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (fifo_ctl),
      .sts   (fifo_sts)
   );

   always_comb begin
      phase_in         = phase_ff;
      bit_in           = bit_ff;
      shift_in         = shift_ff;
      reject_in        = reject_ff;
      line_in          = line_ff;
      acc              = 1'b0;
      frame_done       = 1'b0;
      fifo_ctl.push    = 1'b0;
      fifo_ctl.pop     = 1'b0;
      fifo_ctl.wr_data = wr_byte;
      if (req_fire) begin
         if (is_write) begin
            if (wr_first) begin
               reject_in = (wr_len == '0) || (CMP_W'(wr_len) > CMP_W'(room));
            end
            if (!reject_in && (room != '0)) begin
               acc           = 1'b1;
               fifo_ctl.push = 1'b1;
               if (phase_ff == PH_IDLE) begin
                  bit_in  = '0;
                  line_in = 1'b1;
                  if (PREAMBLE_BITS == 0) begin
                     // idle means FIFO empty: the new byte goes straight out
                     fifo_ctl.pop = 1'b1;
                     shift_in     = wr_byte;
                     phase_in     = PH_START;
                  end else begin
                     phase_in = PH_PRE;
                  end
               end
            end
         end else begin
            unique case (phase_ff)
               PH_PRE: begin
                  line_in = 1'b1;
                  bit_in  = bit_ff + 4'd1;
                  if (bit_in >= 4'(PREAMBLE_BITS)) begin
                     frame_done = 1'b1;
                  end
               end
               PH_START: begin
                  line_in  = 1'b0;
                  bit_in   = '0;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  line_in = shift_ff[bit_ff[2:0]];
                  bit_in  = bit_ff + 4'd1;
                  if (bit_in >= 4'd8) begin
                     bit_in   = '0;
                     phase_in = PH_STOP;
                  end
               end
               PH_STOP: begin
                  line_in = 1'b1;
                  bit_in  = bit_ff + 4'd1;
                  if (bit_in >= 4'(STOP_BITS)) begin
                     frame_done = 1'b1;
                  end
               end
               default: begin
                  line_in  = 1'b1;
                  bit_in   = '0;
                  phase_in = PH_IDLE;
               end
            endcase
            if (frame_done) begin
               bit_in = '0;
               if (fifo_sts.count != '0) begin
                  fifo_ctl.pop = 1'b1;
                  shift_in     = fifo_sts.rd_data;
                  phase_in     = PH_START;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
      end
      count_next = fifo_sts.count + CNT_W'(fifo_ctl.push) - CNT_W'(fifo_ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_ff       <= '0;
         shift_ff     <= '0;
         reject_ff    <= 1'b0;
         line_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         reject_ff <= reject_in;
         line_ff   <= line_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {1'b0, 4'(count_next), (phase_in != PH_IDLE), acc, line_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (fifo_sts.count == '0))
      else $error("transmitter idle with bytes queued");

   a_data_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (bit_ff < 4'd8))
      else $error("data bit index out of range");

   a_tick_no_accept: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser[0]) |=> (rsp_tvalid && !rsp_tdata[1]))
      else $error("tick item reported as accepted");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted item produced no result");
`endif

endmodule
